>>> rtl/core/ctt_pkg.sv
// Types and constants shared by the connection tuple table.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ctt_pkg;

    localparam int CTT_TABLE_ENTRIES = 64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CHECK  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        t_op         opcode;
        logic [31:0] remote_ip;
        logic [31:0] local_ip;
        logic [15:0] peer_port;
        logic [15:0] host_port;
        logic [7:0]  protocol;
        logic [7:0]  owner_thread;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [7:0]  found_thread;
    } t_rsp;

    typedef struct packed {
        logic [31:0] remote_ip;
        logic [31:0] local_ip;
        logic [31:0] ports;
        logic [7:0]  protocol;
        logic [7:0]  owner;
    } t_slot;

    typedef struct packed {
        logic  valid;
        t_slot slot;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic wild;
        logic ins_shift;
        logic del_en;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> rtl/core/ctt_cell.sv
// One slot of the connection tuple table: stored tuple, compare, shift.
// Depends on ctt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctt_cell
    import ctt_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_req  i_req,
    input  wire t_entry i_prev,
    input  wire t_entry i_next,
    input  wire        i_hit_before,
    input  wire  [7:0] i_owner_acc,
    output t_entry     o_entry,
    output logic       o_hit_upto,
    output logic [7:0] o_owner_acc
);

    logic   r_valid;
    t_slot  r_slot;
    logic   r_match;
    logic   w_match;
    logic   w_first;
    logic   w_del_shift;

    always_comb begin
        w_match = r_valid
               && (r_slot.ports == {i_req.peer_port, i_req.host_port})
               && (r_slot.protocol == i_req.protocol)
               && ((r_slot.remote_ip == i_req.remote_ip)
                   || (i_ctl.wild && (i_req.remote_ip == 32'd0)))
               && ((r_slot.local_ip == i_req.local_ip)
                   || (i_ctl.wild && (i_req.local_ip == 32'd0)));
    end

    assign o_hit_upto  = i_hit_before | r_match;
    assign w_first     = r_match & ~i_hit_before;
    assign o_owner_acc = i_owner_acc | (w_first ? r_slot.owner : 8'd0);
    assign w_del_shift = i_ctl.del_en & o_hit_upto;

    assign o_entry.valid = r_valid;
    assign o_entry.slot  = r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.capture) begin
                r_match <= w_match;
            end
            if (i_ctl.ins_shift) begin
                r_valid <= i_prev.valid;
            end else if (w_del_shift) begin
                r_valid <= i_next.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_shift) begin
            r_slot <= i_prev.slot;
        end else if (w_del_shift) begin
            r_slot <= i_next.slot;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/connection_tuple_table.sv
// Top level of the connection tuple table: request/response handshake and
// the chain of ctt_cell slots. Depends on ctt_pkg and ctt_cell.
//
//   channel   direction  valid         ready         payload
//   request   in         i_req_valid   o_req_ready   i_req (t_req)
//   response  out        o_rsp_valid   i_rsp_ready   o_rsp (t_rsp)
//
// On acceptance every cell compares the tuple and registers its match bit;
// then, once the response register is free or being read, the match flag runs
// down the chain, the table shifts and the response is registered.
// A response that is not taken holds this last step and the table.
// Reset (synchronous, active low) empties the table at once.
`timescale 1ns / 1ps
`default_nettype none

module connection_tuple_table
    import ctt_pkg::*;
#(
    parameter int TABLE_ENTRIES = CTT_TABLE_ENTRIES
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_req_valid,
    output logic o_req_ready,
    input  wire t_req i_req,
    output logic o_rsp_valid,
    input  wire  i_rsp_ready,
    output t_rsp o_rsp
);

    logic       r_busy;
    logic       n_busy;
    t_req       r_req;
    logic       r_rsp_valid;
    logic       n_rsp_valid;
    t_rsp       r_rsp;
    t_rsp       n_rsp;
    logic       w_accept;
    logic       w_done;
    logic       w_full;
    logic       w_found;
    t_cell_ctl  w_ctl;
    t_entry     w_head;
    t_entry     w_tail;

    t_entry     w_entry [TABLE_ENTRIES];
    logic       w_hit   [TABLE_ENTRIES];
    logic [7:0] w_owner [TABLE_ENTRIES];

    assign o_req_ready = ~r_busy;
    assign w_accept    = i_req_valid & ~r_busy;
    assign w_done      = r_busy & (~r_rsp_valid | i_rsp_ready);

    assign w_full  = w_entry[TABLE_ENTRIES-1].valid;
    assign w_found = w_hit[TABLE_ENTRIES-1];

    assign w_ctl.capture   = w_accept;
    assign w_ctl.wild      = (i_req.opcode == OP_CHECK);
    assign w_ctl.ins_shift = w_done & (r_req.opcode == OP_INSERT) & ~w_full;
    assign w_ctl.del_en    = w_done & (r_req.opcode == OP_DELETE);

    assign w_head.valid          = 1'b1;
    assign w_head.slot.remote_ip = r_req.remote_ip;
    assign w_head.slot.local_ip  = r_req.local_ip;
    assign w_head.slot.ports     = {r_req.peer_port, r_req.host_port};
    assign w_head.slot.protocol  = r_req.protocol;
    assign w_head.slot.owner     = r_req.owner_thread;

    assign w_tail.valid = 1'b0;
    assign w_tail.slot  = w_entry[TABLE_ENTRIES-1].slot;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        ctt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_req        (i_req),
            .i_prev       ((g == 0) ? w_head : w_entry[(g == 0) ? 0 : g-1]),
            .i_next       ((g == TABLE_ENTRIES-1) ? w_tail
                           : w_entry[(g == TABLE_ENTRIES-1) ? g : g+1]),
            .i_hit_before ((g == 0) ? 1'b0 : w_hit[(g == 0) ? 0 : g-1]),
            .i_owner_acc  ((g == 0) ? 8'd0 : w_owner[(g == 0) ? 0 : g-1]),
            .o_entry      (w_entry[g]),
            .o_hit_upto   (w_hit[g]),
            .o_owner_acc  (w_owner[g])
        );
    end

    always_comb begin
        n_rsp.status       = w_found ? ST_OK : ST_NOT_FOUND;
        n_rsp.found_thread = 8'd0;
        unique case (r_req.opcode)
            OP_INSERT: begin
                n_rsp.status = w_full ? ST_FULL : ST_OK;
            end
            OP_LOOKUP: begin
                n_rsp.found_thread = w_owner[TABLE_ENTRIES-1];
            end
            OP_DELETE, OP_CHECK: begin
                n_rsp.found_thread = 8'd0;
            end
            default: begin
                n_rsp.found_thread = 8'd0;
            end
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        if (w_accept) begin
            n_busy = 1'b1;
        end else if (w_done) begin
            n_busy = 1'b0;
        end
        n_rsp_valid = r_rsp_valid;
        if (w_done) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        if (w_done) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

>>> rtl/core/ctt_checker.sv
// Port-level checks for connection_tuple_table, bound to the top level.
// Depends on ctt_pkg and connection_tuple_table.
`timescale 1ns / 1ps
`default_nettype none

module ctt_checker
    import ctt_pkg::*;
(
    input wire  i_clk,
    input wire  i_rst_n,
    input wire  i_req_valid,
    input wire  o_req_ready,
    input wire t_req i_req,
    input wire  o_rsp_valid,
    input wire  i_rsp_ready,
    input wire t_rsp o_rsp
);

    logic w_accept;
    assign w_accept = i_req_valid & o_req_ready;

    a_rsp_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed");

    a_thread_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.found_thread != 8'd0) |-> o_rsp.status == ST_OK)
        else $error("thread reported without a hit");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_req_ready)
        else $error("request taken while another is in flight");

    a_rsp_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !o_rsp_valid |-> ##2 o_rsp_valid)
        else $error("response missing two cycles after request");

endmodule

bind connection_tuple_table ctt_checker u_ctt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);

`default_nettype wire

>>> test/connection_tuple_table_tb.sv
// Self-checking bench for connection_tuple_table: directed and random requests, with a
// scoreboard that predicts each response from its own copy of the five-tuple table.
// Depends on ctt_pkg and the connection_tuple_table RTL.
`timescale 1ns / 1ps

module connection_tuple_table_tb;
    import ctt_pkg::*;

    localparam int SLOTS       = CTT_TABLE_ENTRIES;
    localparam int PHASE_ITEMS = 457;
    localparam int POOL_SIZE   = 16;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 80;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    t_rsp o_rsp;

    connection_tuple_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_req  req_queue[$];
    t_rsp  pending_rsp[$];
    logic  req_taken = 1'b0;
    int    pushed_total = 0;
    int    req_count = 0;
    int    rsp_count = 0;
    int    mismatches = 0;
    int    sender_idle_pct = 0;
    int    receiver_stall_pct = 0;
    int    hold_left = 0;
    int    next_hold = 60;
    int    full_inserts = 0;
    int    lookup_hits = 0;
    int    wild_checks = 0;

    logic  tbl_valid [SLOTS];
    t_slot tbl_slot  [SLOTS];

    t_req  tuple_pool [POOL_SIZE];
    t_req  issued_tuples[$];

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_slot[i]  = '0;
        end
    end

    function automatic int newest_match(t_req r, bit wild);
        logic [31:0] ports;
        ports = {r.peer_port, r.host_port};
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i] && tbl_slot[i].ports == ports
                    && tbl_slot[i].protocol == r.protocol
                    && (tbl_slot[i].remote_ip == r.remote_ip || (wild && r.remote_ip == '0))
                    && (tbl_slot[i].local_ip == r.local_ip || (wild && r.local_ip == '0)))
                return i;
        end
        return -1;
    endfunction

    function automatic t_rsp apply_table_op(t_req r);
        t_rsp rsp;
        int   hit;
        rsp.status       = ST_NOT_FOUND;
        rsp.found_thread = '0;
        case (r.opcode)
            OP_INSERT: begin
                if (tbl_valid[SLOTS-1]) begin
                    rsp.status = ST_FULL;
                    full_inserts++;
                end else begin
                    for (int i = SLOTS - 1; i > 0; i--) begin
                        tbl_valid[i] = tbl_valid[i-1];
                        tbl_slot[i]  = tbl_slot[i-1];
                    end
                    tbl_valid[0] = 1'b1;
                    tbl_slot[0]  = '{remote_ip: r.remote_ip, local_ip: r.local_ip,
                                     ports: {r.peer_port, r.host_port},
                                     protocol: r.protocol, owner: r.owner_thread};
                    rsp.status = ST_OK;
                end
            end
            OP_DELETE: begin
                hit = newest_match(r, 1'b0);
                if (hit >= 0) begin
                    for (int i = hit; i < SLOTS - 1; i++) begin
                        tbl_valid[i] = tbl_valid[i+1];
                        tbl_slot[i]  = tbl_slot[i+1];
                    end
                    tbl_valid[SLOTS-1] = 1'b0;
                    rsp.status = ST_OK;
                end
            end
            OP_LOOKUP: begin
                hit = newest_match(r, 1'b0);
                if (hit >= 0) begin
                    rsp.status       = ST_OK;
                    rsp.found_thread = tbl_slot[hit].owner;
                    lookup_hits++;
                end
            end
            default: begin
                hit = newest_match(r, 1'b1);
                if (r.remote_ip == '0 || r.local_ip == '0)
                    wild_checks++;
                if (hit >= 0)
                    rsp.status = ST_OK;
            end
        endcase
        return rsp;
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else if (!i_req_valid || req_taken) begin
            if (req_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                i_req       <= req_queue.pop_front();
                i_req_valid <= 1'b1;
            end else begin
                i_req_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_rsp_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (req_count >= next_hold) begin
            i_rsp_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            next_hold   <= (next_hold < 300) ? 300 : 32'h7fff_ffff;
        end else begin
            i_rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_rsp want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_req_valid && o_req_ready;
            if (o_rsp_valid && i_rsp_ready) begin
                rsp_count++;
                if (pending_rsp.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected response: status %0d thread %02h",
                                 o_rsp.status, o_rsp.found_thread);
                    mismatches++;
                end else begin
                    want = pending_rsp.pop_front();
                    if (o_rsp.status !== want.status
                            || o_rsp.found_thread !== want.found_thread) begin
                        if (mismatches < 10)
                            $display("response %0d: expected status %0d thread %02h, got %0d %02h",
                                     rsp_count, want.status, want.found_thread,
                                     o_rsp.status, o_rsp.found_thread);
                        mismatches++;
                    end
                end
            end
            if (i_req_valid && o_req_ready) begin
                pending_rsp.push_back(apply_table_op(i_req));
                req_count++;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("connection_tuple_table_tb: done, errors");
        $finish;
    end

    function automatic logic [31:0] pick_ip();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        if (roll < 15)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_port();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return '1;
        return 16'($urandom);
    endfunction

    function automatic t_req fresh_tuple();
        t_req r;
        int   roll;
        r.opcode       = OP_INSERT;
        r.remote_ip    = pick_ip();
        r.local_ip     = pick_ip();
        r.peer_port    = pick_port();
        r.host_port    = pick_port();
        r.owner_thread = 8'($urandom);
        roll = $urandom_range(99);
        if (roll < 10)
            r.protocol = '0;
        else if (roll < 20)
            r.protocol = '1;
        else if (roll < 45)
            r.protocol = 8'd6;
        else if (roll < 60)
            r.protocol = 8'd17;
        else
            r.protocol = 8'($urandom);
        return r;
    endfunction

    function automatic t_req near_miss(t_req r);
        case ($urandom_range(4))
            0: r.remote_ip                       = r.remote_ip ^ (32'd1 << $urandom_range(31));
            1: r.local_ip                        = r.local_ip ^ (32'd1 << $urandom_range(31));
            2: r.peer_port                       = r.peer_port ^ (16'd1 << $urandom_range(15));
            3: r.host_port                       = r.host_port ^ (16'd1 << $urandom_range(15));
            default: r.protocol                  = r.protocol ^ (8'd1 << $urandom_range(7));
        endcase
        return r;
    endfunction

    task automatic queue_req(t_req r);
        req_queue.push_back(r);
        pushed_total++;
    endtask

    task automatic queue_op(t_op op);
        t_req r;
        int   roll;
        int   idx;
        roll = $urandom_range(99);
        if (op == OP_INSERT) begin
            if (roll < 20 && issued_tuples.size() != 0)
                r = issued_tuples[$urandom_range(issued_tuples.size() - 1)];
            else if (roll < 65)
                r = tuple_pool[$urandom_range(POOL_SIZE - 1)];
            else
                r = fresh_tuple();
            issued_tuples.push_back(r);
            if (issued_tuples.size() > SLOTS)
                void'(issued_tuples.pop_front());
        end else begin
            if (roll < 70 && issued_tuples.size() != 0) begin
                idx = $urandom_range(issued_tuples.size() - 1);
                r = issued_tuples[idx];
                if (op == OP_DELETE)
                    issued_tuples.delete(idx);
            end else if (roll < 85) begin
                r = near_miss(tuple_pool[$urandom_range(POOL_SIZE - 1)]);
            end else begin
                r = tuple_pool[$urandom_range(POOL_SIZE - 1)];
            end
            if (op == OP_CHECK) begin
                case ($urandom_range(5))
                    0: r.remote_ip = '0;
                    1: r.local_ip = '0;
                    2: begin
                        r.remote_ip = '0;
                        r.local_ip  = '0;
                    end
                    default: ;
                endcase
            end
        end
        r.opcode       = op;
        r.owner_thread = 8'($urandom);
        queue_req(r);
    endtask

    task automatic queue_random_phase(int count);
        int left;
        int len;
        int kind;
        int roll;
        int ins_w;
        int del_w;
        int look_w;
        left = count;
        for (int i = 0; i < POOL_SIZE; i++)
            tuple_pool[i] = fresh_tuple();
        for (int i = 0; i < SLOTS + 6; i++)
            queue_op(OP_INSERT);
        for (int i = 0; i < 6; i++)
            queue_op(($urandom_range(1) != 0) ? OP_LOOKUP : OP_CHECK);
        left -= SLOTS + 12;
        while (left > 0) begin
            for (int i = 0; i < 3; i++)
                tuple_pool[$urandom_range(POOL_SIZE - 1)] = fresh_tuple();
            kind = $urandom_range(2);
            len  = $urandom_range(20, 60);
            case (kind)
                0: begin ins_w = 60; del_w = 10; look_w = 15; end
                1: begin ins_w = 10; del_w = 50; look_w = 20; end
                default: begin ins_w = 25; del_w = 25; look_w = 25; end
            endcase
            for (int i = 0; i < len && left > 0; i++, left--) begin
                roll = $urandom_range(99);
                if (roll < ins_w)
                    queue_op(OP_INSERT);
                else if (roll < ins_w + del_w)
                    queue_op(OP_DELETE);
                else if (roll < ins_w + del_w + look_w)
                    queue_op(OP_LOOKUP);
                else
                    queue_op(OP_CHECK);
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (req_count != pushed_total || pending_rsp.size() != 0);
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_req tup_a;
        t_req tup_b;
        t_req tup_c;
        t_req r;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tup_a = '{OP_INSERT, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff, 8'hff, 8'hff};
        tup_b = '{OP_INSERT, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 8'h0};
        tup_c = '{OP_INSERT, 32'h0a00_0001, 32'hc0a8_0001, 16'h0050, 16'h1f90, 8'd6, 8'h11};

        r = tup_a; r.opcode = OP_LOOKUP; queue_req(r);
        r = tup_a; r.opcode = OP_DELETE; queue_req(r);
        r = tup_a; r.opcode = OP_CHECK; r.remote_ip = '0; r.local_ip = '0; queue_req(r);
        queue_req(tup_a);
        queue_req(tup_b);
        queue_req(tup_c);
        r = tup_a; r.opcode = OP_LOOKUP; queue_req(r);
        r = tup_b; r.opcode = OP_LOOKUP; queue_req(r);
        r = tup_c; r.opcode = OP_CHECK; r.remote_ip = '0; r.local_ip = '0; queue_req(r);
        r = tup_c; r.opcode = OP_CHECK; r.remote_ip = '0; queue_req(r);
        r = tup_c; r.opcode = OP_CHECK; r.local_ip = '0; r.peer_port = 16'h0051; queue_req(r);
        r = tup_c; r.opcode = OP_LOOKUP; r.protocol = 8'd17; queue_req(r);
        r = tup_c; r.opcode = OP_LOOKUP; r.remote_ip = '0; queue_req(r);
        r = tup_a; r.owner_thread = 8'h5a; queue_req(r);
        r = tup_a; r.opcode = OP_LOOKUP; queue_req(r);
        r = tup_a; r.opcode = OP_DELETE; queue_req(r);
        r = tup_a; r.opcode = OP_LOOKUP; queue_req(r);
        r = tup_a; r.opcode = OP_DELETE; queue_req(r);
        r = tup_a; r.opcode = OP_LOOKUP; queue_req(r);
        r = tup_b; r.opcode = OP_CHECK; queue_req(r);
        r = tup_b; r.opcode = OP_DELETE; queue_req(r);
        r = tup_c; r.opcode = OP_DELETE; queue_req(r);
        r = tup_b; r.opcode = OP_CHECK; queue_req(r);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 78; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 78; end
                default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
            endcase
            queue_random_phase(PHASE_ITEMS);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("connection_tuple_table_tb: %0d requests, %0d responses checked",
                 req_count, rsp_count);
        $display({"connection_tuple_table_tb: %0d inserts on a full table, ",
                  "%0d lookup hits, %0d wildcard checks"},
                 full_inserts, lookup_hits, wild_checks);
        if (mismatches == 0)
            $display("connection_tuple_table_tb: done, clean");
        else
            $display("connection_tuple_table_tb: done, errors");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/ctt_pkg.sv
rtl/core/ctt_cell.sv
rtl/core/connection_tuple_table.sv
rtl/core/ctt_checker.sv
test/connection_tuple_table_tb.sv
